// ----- src/rrd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types, constants and CRC helpers for the reader response deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrd_pkg;

  localparam logic [7:0]  FRAME_HEADER     = 8'hFF;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] STATUS_KEEPALIVE = 16'h0400;
  localparam logic [15:0] STATUS_THROTTLE  = 16'h0504;
  localparam logic [7:0]  LEN_UNKNOWN      = 8'h08;
  localparam logic [7:0]  LEN_TEMPERATURE  = 8'h0A;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_EXPECTED_OPCODE  = 8'd0,
    REG_CLASSIFY_RECORDS = 8'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    VERDICT_GOOD        = 3'd0,
    VERDICT_CRC_ERROR   = 3'd1,
    VERDICT_WRONG_OP    = 3'd2,
    VERDICT_KEEPALIVE   = 3'd3,
    VERDICT_THROTTLE    = 3'd4,
    VERDICT_UNKNOWN     = 3'd5,
    VERDICT_TEMPERATURE = 3'd6,
    VERDICT_TAG         = 3'd7
  } verdict_t;

  // Frame byte positions after the header
  localparam logic [8:0] POS_LEN       = 9'd1;
  localparam logic [8:0] POS_OPCODE    = 9'd2;
  localparam logic [8:0] POS_STATUS_HI = 9'd3;
  localparam logic [8:0] POS_STATUS_LO = 9'd4;
  localparam logic [8:0] POS_PAYLOAD   = 9'd5;

  function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
    logic [15:0] t;
    t = {crc[15:12], 12'h000};
    for (int k = 0; k < 4; k++) begin
      if (t[15]) t = {t[14:0], 1'b0} ^ CRC_POLY;
      else       t = {t[14:0], 1'b0};
    end
    return {crc[11:0], nib} ^ t;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    return crc_nibble(crc_nibble(crc, b[7:4]), b[3:0]);
  endfunction

endpackage

`default_nettype wire

// ----- src/rrd_if.sv -----
// ----------------------------------------------------------------------------
// rrd_if
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrd_res_if;
  logic        valid;
  logic        ready;
  logic        is_verdict;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [2:0]  verdict;
  logic [7:0]  frame_opcode;
  logic [15:0] frame_status;
  logic [7:0]  frame_length;
  modport source (output valid, output is_verdict, output payload_byte, output payload_index,
                  output verdict, output frame_opcode, output frame_status,
                  output frame_length, input ready);
  modport sink   (input valid, input is_verdict, input payload_byte, input payload_index,
                  input verdict, input frame_opcode, input frame_status,
                  input frame_length, output ready);
endinterface

interface rrd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrd_pkg::CFG_INDEX_W-1:0] index;
  logic [rrd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/reader_response_deframer_top.sv -----
// ----------------------------------------------------------------------------
// reader_response_deframer_top
// Hunts for frame headers, checks CRC-16, streams payload and gives a verdict.
// ----------------------------------------------------------------------------
// Output: each result word is registered and shown in the cycle after its byte.
// Throughput: one byte per cycle while res.ready does not hold a result back;
//   the two nibble CRC steps sit between the input byte and the CRC register.
// Reset: synchronous; hunting for a header, registers at expected opcode 34
//   and classification on, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module reader_response_deframer_top (
  input  wire logic clk,
  input  wire logic rst,
  rrd_rx_if.sink    rx,
  rrd_res_if.source res,
  rrd_cfg_if.sink   cfg
);

  logic        in_frame;
  logic [8:0]  byte_position;
  logic [7:0]  payload_length;
  logic [7:0]  held_opcode;
  logic [15:0] held_status;
  logic [15:0] running_crc;
  logic        crc_high_ok;
  logic [7:0]  expected_opcode;
  logic        classify_records;

  logic        out_valid;
  logic        out_is_verdict;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_index;
  logic [2:0]  out_verdict;
  logic [7:0]  out_frame_opcode;
  logic [15:0] out_frame_status;
  logic [7:0]  out_frame_length;

  logic        in_frame_next;
  logic [8:0]  byte_position_next;
  logic [7:0]  payload_length_next;
  logic [7:0]  held_opcode_next;
  logic [15:0] held_status_next;
  logic [15:0] running_crc_next;
  logic        crc_high_ok_next;
  logic        emit;
  logic        emit_verdict;
  logic [2:0]  verdict_next;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [8:0]  payload_end;
  logic [8:0]  pos_plus1;
  logic        crc_ok;

  assign accept      = rx.valid & rx.ready;
  assign rx.ready    = ~out_valid | res.ready;
  assign cfg.ready   = 1'b1;
  assign b           = rx.rx_byte;
  assign crc_upd     = rrd_pkg::crc_byte(running_crc, b);
  assign payload_end = rrd_pkg::POS_PAYLOAD + {1'b0, payload_length};
  assign pos_plus1   = byte_position + 9'd1;
  assign crc_ok      = crc_high_ok & (b == running_crc[7:0]);

  always_comb begin
    if (!crc_ok)                              verdict_next = rrd_pkg::VERDICT_CRC_ERROR;
    else if (held_opcode != expected_opcode)  verdict_next = rrd_pkg::VERDICT_WRONG_OP;
    else if (!classify_records)               verdict_next = rrd_pkg::VERDICT_GOOD;
    else if (payload_length == 8'd0) begin
      if (held_status == rrd_pkg::STATUS_KEEPALIVE)     verdict_next = rrd_pkg::VERDICT_KEEPALIVE;
      else if (held_status == rrd_pkg::STATUS_THROTTLE) verdict_next = rrd_pkg::VERDICT_THROTTLE;
      else                                              verdict_next = rrd_pkg::VERDICT_UNKNOWN;
    end
    else if (payload_length == rrd_pkg::LEN_UNKNOWN)     verdict_next = rrd_pkg::VERDICT_UNKNOWN;
    else if (payload_length == rrd_pkg::LEN_TEMPERATURE) verdict_next = rrd_pkg::VERDICT_TEMPERATURE;
    else                                                 verdict_next = rrd_pkg::VERDICT_TAG;
  end

  always_comb begin
    in_frame_next       = in_frame;
    byte_position_next  = byte_position;
    payload_length_next = payload_length;
    held_opcode_next    = held_opcode;
    held_status_next    = held_status;
    running_crc_next    = running_crc;
    crc_high_ok_next    = crc_high_ok;
    emit                = 1'b0;
    emit_verdict        = 1'b0;
    if (!in_frame) begin
      if (b == rrd_pkg::FRAME_HEADER) begin
        in_frame_next      = 1'b1;
        byte_position_next = rrd_pkg::POS_LEN;
        running_crc_next   = rrd_pkg::CRC_INIT;
        crc_high_ok_next   = 1'b0;
      end
    end else if (byte_position < rrd_pkg::POS_PAYLOAD) begin
      case (byte_position)
        rrd_pkg::POS_LEN:       payload_length_next = b;
        rrd_pkg::POS_OPCODE:    held_opcode_next    = b;
        rrd_pkg::POS_STATUS_HI: held_status_next    = {b, 8'h00};
        rrd_pkg::POS_STATUS_LO: held_status_next    = {held_status[15:8], b};
        default:                ;
      endcase
      running_crc_next   = crc_upd;
      byte_position_next = pos_plus1;
    end else if (byte_position < payload_end) begin
      running_crc_next   = crc_upd;
      byte_position_next = pos_plus1;
      emit               = 1'b1;
    end else if (byte_position == payload_end) begin
      crc_high_ok_next   = (b == running_crc[15:8]);
      byte_position_next = pos_plus1;
    end else begin
      emit               = 1'b1;
      emit_verdict       = 1'b1;
      in_frame_next      = 1'b0;
      byte_position_next = 9'd0;
      crc_high_ok_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      byte_position    <= 9'd0;
      payload_length   <= 8'd0;
      held_opcode      <= 8'd0;
      held_status      <= 16'd0;
      running_crc      <= rrd_pkg::CRC_INIT;
      crc_high_ok      <= 1'b0;
      expected_opcode  <= 8'd34;
      classify_records <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        in_frame       <= in_frame_next;
        byte_position  <= byte_position_next;
        payload_length <= payload_length_next;
        held_opcode    <= held_opcode_next;
        held_status    <= held_status_next;
        running_crc    <= running_crc_next;
        crc_high_ok    <= crc_high_ok_next;
      end
      if (cfg.valid) begin
        case (cfg.index)
          rrd_pkg::REG_EXPECTED_OPCODE:  expected_opcode  <= cfg.data[7:0];
          rrd_pkg::REG_CLASSIFY_RECORDS: classify_records <= cfg.data[0];
          default:                       ;
        endcase
      end
      if (accept) out_valid <= emit;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_is_verdict <= emit_verdict;
      if (emit_verdict) begin
        out_payload_byte  <= 8'd0;
        out_payload_index <= 8'd0;
        out_verdict       <= verdict_next;
        out_frame_opcode  <= held_opcode;
        out_frame_status  <= held_status;
        out_frame_length  <= payload_length;
      end else begin
        out_payload_byte  <= b;
        out_payload_index <= byte_position[7:0] - 8'd5;
        out_verdict       <= rrd_pkg::VERDICT_GOOD;
        out_frame_opcode  <= 8'd0;
        out_frame_status  <= 16'd0;
        out_frame_length  <= 8'd0;
      end
    end
  end

  assign res.valid         = out_valid;
  assign res.is_verdict    = out_is_verdict;
  assign res.payload_byte  = out_payload_byte;
  assign res.payload_index = out_payload_index;
  assign res.verdict       = out_verdict;
  assign res.frame_opcode  = out_frame_opcode;
  assign res.frame_status  = out_frame_status;
  assign res.frame_length  = out_frame_length;

endmodule

`default_nettype wire

// ----- tb/rrd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// rrd_tb_pkg
// Frame scoreboard for the reader response deframer: tracks the deframer state
// byte by byte, queues the words each byte should produce, checks arrivals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrd_tb_pkg;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [2:0]  verdict;
    logic [7:0]  frame_opcode;
    logic [15:0] frame_status;
    logic [7:0]  frame_length;
  } res_word_t;

  class frame_scoreboard;
    logic [7:0]  exp_opcode;
    logic        classify_on;
    logic        in_frame;
    logic [8:0]  pos;
    logic [7:0]  len;
    logic [7:0]  opcode;
    logic [15:0] status;
    logic [15:0] crc;
    logic        crc_hi_match;
    res_word_t   expected_words[$];
    int unsigned mismatches;
    int unsigned payload_words;
    int unsigned verdict_words;
    int unsigned verdict_hits[8];

    function new();
      exp_opcode    = 8'd34;
      classify_on   = 1'b1;
      in_frame      = 1'b0;
      pos           = '0;
      len           = '0;
      opcode        = '0;
      status        = '0;
      crc           = rrd_pkg::CRC_INIT;
      crc_hi_match  = 1'b0;
      mismatches    = 0;
      payload_words = 0;
      verdict_words = 0;
      foreach (verdict_hits[i]) verdict_hits[i] = 0;
    endfunction

    function void write_reg(logic [rrd_pkg::CFG_INDEX_W-1:0] idx,
                            logic [rrd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rrd_pkg::REG_EXPECTED_OPCODE:  exp_opcode = val;
        rrd_pkg::REG_CLASSIFY_RECORDS: classify_on = val[0];
        default: ;
      endcase
    endfunction

    // bit-serial form of the nibble-fed CRC: data bits enter at the bottom
    function logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15];
        c  = {c[14:0], b[i]};
        if (fb) c = c ^ rrd_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function rrd_pkg::verdict_t frame_verdict(logic crc_ok);
      if (!crc_ok) return rrd_pkg::VERDICT_CRC_ERROR;
      if (opcode != exp_opcode) return rrd_pkg::VERDICT_WRONG_OP;
      if (!classify_on) return rrd_pkg::VERDICT_GOOD;
      if (len == 8'd0) begin
        if (status == rrd_pkg::STATUS_KEEPALIVE) return rrd_pkg::VERDICT_KEEPALIVE;
        if (status == rrd_pkg::STATUS_THROTTLE) return rrd_pkg::VERDICT_THROTTLE;
        return rrd_pkg::VERDICT_UNKNOWN;
      end
      if (len == rrd_pkg::LEN_UNKNOWN) return rrd_pkg::VERDICT_UNKNOWN;
      if (len == rrd_pkg::LEN_TEMPERATURE) return rrd_pkg::VERDICT_TEMPERATURE;
      return rrd_pkg::VERDICT_TAG;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      res_word_t w;
      w = '0;
      if (!in_frame) begin
        if (b == rrd_pkg::FRAME_HEADER) begin
          in_frame     = 1'b1;
          pos          = rrd_pkg::POS_LEN;
          crc          = rrd_pkg::CRC_INIT;
          crc_hi_match = 1'b0;
        end
        return;
      end
      if (pos == rrd_pkg::POS_LEN) begin
        len = b;
      end else if (pos == rrd_pkg::POS_OPCODE) begin
        opcode = b;
      end else if (pos == rrd_pkg::POS_STATUS_HI) begin
        status = {b, 8'h00};
      end else if (pos == rrd_pkg::POS_STATUS_LO) begin
        status[7:0] = b;
      end else if (pos < rrd_pkg::POS_PAYLOAD + len) begin
        w.payload_byte  = b;
        w.payload_index = 8'(pos - rrd_pkg::POS_PAYLOAD);
        expected_words.push_back(w);
      end else if (pos == rrd_pkg::POS_PAYLOAD + len) begin
        crc_hi_match = (b == crc[15:8]);
        pos = pos + 9'd1;
        return;
      end else begin
        w.is_verdict   = 1'b1;
        w.verdict      = frame_verdict(crc_hi_match && (b == crc[7:0]));
        w.frame_opcode = opcode;
        w.frame_status = status;
        w.frame_length = len;
        expected_words.push_back(w);
        in_frame     = 1'b0;
        pos          = '0;
        crc_hi_match = 1'b0;
        return;
      end
      crc = crc_add(crc, b);
      pos = pos + 9'd1;
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result_word(res_word_t got);
      res_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("word with nothing expected: %p", got));
        return;
      end
      want = expected_words.pop_front();
      check_field("is_verdict",    got.is_verdict,    want.is_verdict);
      check_field("payload_byte",  got.payload_byte,  want.payload_byte);
      check_field("payload_index", got.payload_index, want.payload_index);
      check_field("verdict",       got.verdict,       want.verdict);
      check_field("frame_opcode",  got.frame_opcode,  want.frame_opcode);
      check_field("frame_status",  got.frame_status,  want.frame_status);
      check_field("frame_length",  got.frame_length,  want.frame_length);
      if (want.is_verdict) begin
        verdict_words++;
        verdict_hits[want.verdict]++;
      end else begin
        payload_words++;
      end
    endtask
  endclass

endpackage

// ----- tb/tb_reader_response_deframer_top.sv -----
// ----------------------------------------------------------------------------
// tb_reader_response_deframer_top
// Streams well-formed, corrupted and truncated reader frames plus line noise
// into the deframer under several register settings, with random gaps and
// stalls on both channels, and checks every result word against the
// scoreboard's own tracking of the frame state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reader_response_deframer_top;

  localparam int CORRUPT_NONE   = 0;
  localparam int CORRUPT_CRC_HI = 1;
  localparam int CORRUPT_CRC_LO = 2;
  localparam int CORRUPT_BODY   = 3;

  logic clk;
  logic rst;

  rrd_rx_if  rx_ch ();
  rrd_res_if res_ch ();
  rrd_cfg_if cfg_ch ();

  reader_response_deframer_top uut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  rrd_tb_pkg::frame_scoreboard sb;
  bit              quiet;
  bit              long_hold;
  int unsigned     bytes_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    int stall_left;
    int g;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (long_hold) begin
        long_hold    = 1'b0;
        stall_left   = 300;
        res_ch.ready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          res_ch.ready <= 1'b0;
          stall_left   = g - 1;
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    rrd_tb_pkg::res_word_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (rx_ch.valid && rx_ch.ready) sb.note_rx_byte(rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready) begin
        got.is_verdict    = res_ch.is_verdict;
        got.payload_byte  = res_ch.payload_byte;
        got.payload_index = res_ch.payload_index;
        got.verdict       = res_ch.verdict;
        got.frame_opcode  = res_ch.frame_opcode;
        got.frame_status  = res_ch.frame_status;
        got.frame_length  = res_ch.frame_length;
        sb.check_result_word(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    if (gap > 0) begin
      @(negedge clk);
      rx_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] op,
                            input logic [15:0] st, input int corrupt, input int cut);
    logic [7:0]  fb[$];
    logic [15:0] c;
    int          k;
    int          n;
    fb.push_back(rrd_pkg::FRAME_HEADER);
    fb.push_back(len);
    fb.push_back(op);
    fb.push_back(st[15:8]);
    fb.push_back(st[7:0]);
    for (k = 0; k < len; k++)
      fb.push_back(($urandom_range(0, 5) == 0) ? rrd_pkg::FRAME_HEADER
                                                : 8'($urandom_range(0, 255)));
    c = rrd_pkg::CRC_INIT;
    for (k = 1; k < fb.size(); k++) c = sb.crc_add(c, fb[k]);
    fb.push_back(c[15:8]);
    fb.push_back(c[7:0]);
    case (corrupt)
      CORRUPT_CRC_HI: fb[fb.size()-2] ^= 8'(1 << $urandom_range(0, 7));
      CORRUPT_CRC_LO: fb[fb.size()-1] ^= 8'(1 << $urandom_range(0, 7));
      CORRUPT_BODY: begin
        k = $urandom_range(2, 4 + len);
        fb[k] ^= 8'(1 << $urandom_range(0, 7));
      end
      default: ;
    endcase
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (k = 0; k < n; k++) send_byte(fb[k]);
    bytes_sent += n;
  endtask

  task automatic random_frame(input int cut);
    int          r;
    logic [7:0]  len;
    logic [7:0]  op;
    logic [15:0] st;
    int          corrupt;
    r = $urandom_range(0, 99);
    if (r < 25)      len = 8'd0;
    else if (r < 40) len = rrd_pkg::LEN_UNKNOWN;
    else if (r < 55) len = rrd_pkg::LEN_TEMPERATURE;
    else if (r < 95) len = 8'($urandom_range(1, 16));
    else             len = 8'($urandom_range(100, 255));
    op = ($urandom_range(0, 9) < 7) ? sb.exp_opcode : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 20)      st = rrd_pkg::STATUS_KEEPALIVE;
    else if (r < 40) st = rrd_pkg::STATUS_THROTTLE;
    else if (r < 50) st = 16'h0000;
    else if (r < 55) st = 16'hFFFF;
    else             st = 16'($urandom_range(0, 65535));
    corrupt = ($urandom_range(0, 99) < 80) ? CORRUPT_NONE : $urandom_range(1, 3);
    send_frame(len, op, st, corrupt, cut);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rrd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rrd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // run out any half-received frame with zero fill, then reprogram
  task automatic set_config(input logic [7:0] op, input logic cls);
    @(negedge clk);
    while (sb.in_frame) begin
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= 8'h00;
      @(posedge clk);
      while (!rx_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    rx_ch.valid <= 1'b0;
    wait_idle();
    write_reg(rrd_pkg::REG_EXPECTED_OPCODE, op);
    write_reg(rrd_pkg::REG_CLASSIFY_RECORDS, {7'($urandom_range(0, 127)), cls});
    if ($urandom_range(0, 1))
      write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    int target;
    int r;
    int k;
    sb            = new();
    quiet         = 1'b1;
    long_hold     = 1'b0;
    bytes_sent    = 0;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: line noise, every record class, CRC and opcode errors
    send_byte(8'h00);
    send_byte(8'hFE);
    send_frame(8'd0, 8'd34, rrd_pkg::STATUS_KEEPALIVE, CORRUPT_NONE, 0);
    send_frame(8'd0, 8'd34, rrd_pkg::STATUS_THROTTLE, CORRUPT_NONE, 0);
    send_frame(8'd0, 8'd34, 16'hFFFF, CORRUPT_NONE, 0);
    send_frame(rrd_pkg::LEN_UNKNOWN, 8'd34, 16'h0000, CORRUPT_NONE, 0);
    send_frame(rrd_pkg::LEN_TEMPERATURE, 8'd34, 16'h1234, CORRUPT_NONE, 0);
    send_frame(8'd1, 8'd34, rrd_pkg::STATUS_KEEPALIVE, CORRUPT_NONE, 0);
    send_frame(8'd0, 8'd34, rrd_pkg::STATUS_KEEPALIVE, CORRUPT_CRC_HI, 0);
    send_frame(8'd0, 8'd34, rrd_pkg::STATUS_KEEPALIVE, CORRUPT_CRC_LO, 0);
    send_frame(8'd0, 8'h00, rrd_pkg::STATUS_KEEPALIVE, CORRUPT_NONE, 0);
    set_config(8'hFF, 1'b0);
    send_frame(8'd2, 8'hFF, 16'h0400, CORRUPT_NONE, 0);
    send_frame(8'd0, 8'd34, 16'h0504, CORRUPT_NONE, 0);
    quiet = 1'b0;

    // hold the result side off while a maximum-length frame streams in
    wait_idle();
    quiet     = 1'b1;
    long_hold = 1'b1;
    send_frame(8'd255, 8'hFF, 16'hA5A5, CORRUPT_NONE, 0);
    quiet = 1'b0;
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(8'd34, 1'b1);
        1: set_config(8'h00, 1'b1);
        2: set_config(8'hFF, 1'b1);
        3: set_config(8'h00, 1'b0);
        default: set_config(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
      target = bytes_sent + 40;
      while (bytes_sent < target) begin
        quiet = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        if (r < 80) begin
          random_frame(0);
        end else if (r < 90) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
        end else begin
          random_frame($urandom_range(2, 6));
        end
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    rx_ch.valid <= 1'b0;
    for (k = 0; k < 20000 && sb.expected_words.size() != 0; k++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.expected_words.size() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.expected_words.size()));

    $display("Run covered %0d frame bytes, %0d payload words and %0d verdicts.",
             bytes_sent, sb.payload_words, sb.verdict_words);
    $display("Verdicts: good %0d crc %0d opcode %0d keepalive %0d throttle %0d",
             sb.verdict_hits[rrd_pkg::VERDICT_GOOD], sb.verdict_hits[rrd_pkg::VERDICT_CRC_ERROR],
             sb.verdict_hits[rrd_pkg::VERDICT_WRONG_OP], sb.verdict_hits[rrd_pkg::VERDICT_KEEPALIVE],
             sb.verdict_hits[rrd_pkg::VERDICT_THROTTLE],
             " unknown %0d temp %0d tag %0d",
             sb.verdict_hits[rrd_pkg::VERDICT_UNKNOWN],
             sb.verdict_hits[rrd_pkg::VERDICT_TEMPERATURE], sb.verdict_hits[rrd_pkg::VERDICT_TAG]);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rrd_pkg.sv
src/rrd_if.sv
src/reader_response_deframer_top.sv
tb/rrd_tb_pkg.sv
tb/tb_reader_response_deframer_top.sv
